// File: rtl/core/crcfr_pkg.sv
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the frame receiver.
`default_nettype none

package crcfr_pkg;

  localparam logic [15:0] CrcSeed = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  StartByteRst = 8'hAA;

  localparam logic KindFrame = 1'b0;
  localparam logic KindRead  = 1'b1;

  typedef enum logic [1:0] {
    OP_RECV   = 2'd0,
    OP_READ   = 2'd1,
    OP_RESYNC = 2'd2
  } crcfr_op_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CRC     = 2'd3
  } crcfr_phase_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } crcfr_rx_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
    logic [7:0] read_data;
  } crcfr_res_t;

  // payload store write request
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } crcfr_wr_t;

  // completed good frame
  typedef struct packed {
    logic       good;
    logic [7:0] id;
    logic [7:0] len;
  } crcfr_frame_t;

  // MSB-first, one bit per step
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/crcfr_chan_if.sv
// Valid/ready channel carrying one payload beat per handshake.
`default_nettype none

interface crcfr_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/crcfr_store.sv
// Payload store: 256 x 8 synchronous RAM, one write and one registered read port.
`default_nettype none

module crcfr_store import crcfr_pkg::*; (
  input  logic       clk_i,
  input  crcfr_wr_t  wr_i,
  input  logic       rd_en_i,
  input  logic [7:0] rd_addr_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem [256];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // read data holds until the next read, so a stalled result keeps its byte
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/core/crcfr_parser.sv
// Frame parser: phase tracking, running CRC and payload write requests.
`default_nettype none

module crcfr_parser import crcfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         byte_valid_i,
  input  logic         resync_i,
  input  logic [7:0]   byte_i,
  input  logic [7:0]   start_byte_i,
  output crcfr_wr_t    wr_o,
  output crcfr_frame_t frame_o,
  output logic [7:0]   count_o
);

  crcfr_phase_e phase_q, phase_d;
  logic         hdr_pos_q, hdr_pos_d;
  logic [7:0]   id_q, id_d;
  logic [7:0]   len_q, len_d;
  logic [7:0]   count_q, count_d;
  logic [15:0]  crc_q, crc_d;
  logic [7:0]   crc_low_q, crc_low_d;
  logic [1:0]   crc_cnt_q, crc_cnt_d;

  logic [15:0]  crc_upd;
  logic [7:0]   count_inc;

  assign crc_upd   = crc16_byte(crc_q, byte_i);
  assign count_inc = count_q + 8'd1;

  // next state
  always_comb begin
    phase_d   = phase_q;
    hdr_pos_d = hdr_pos_q;
    id_d      = id_q;
    len_d     = len_q;
    count_d   = count_q;
    crc_d     = crc_q;
    crc_low_d = crc_low_q;
    crc_cnt_d = crc_cnt_q;
    if (resync_i) begin
      phase_d   = PH_IDLE;
      hdr_pos_d = 1'b0;
      crc_cnt_d = 2'd0;
      count_d   = 8'd0;
      crc_d     = CrcSeed;
    end else if (byte_valid_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (byte_i == start_byte_i) begin
            phase_d   = PH_HEADER;
            hdr_pos_d = 1'b0;
            count_d   = 8'd0;
            crc_d     = CrcSeed;
          end
        end
        PH_HEADER: begin
          crc_d = crc_upd;
          if (!hdr_pos_q) begin
            id_d      = byte_i;
            hdr_pos_d = 1'b1;
          end else begin
            len_d     = byte_i;
            hdr_pos_d = 1'b0;
            count_d   = 8'd0;
            crc_cnt_d = 2'd0;
            crc_low_d = 8'd0;
            phase_d   = (byte_i == 8'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_d   = crc_upd;
          count_d = count_inc;
          if (count_inc >= len_q) begin
            crc_cnt_d = 2'd0;
            crc_low_d = 8'd0;
            phase_d   = PH_CRC;
          end
        end
        PH_CRC: begin
          if (crc_cnt_q == 2'd0) begin
            crc_low_d = byte_i;
            crc_cnt_d = 2'd1;
          end else begin
            crc_cnt_d = 2'd2;
            phase_d   = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    wr_o.en      = byte_valid_i && !resync_i && (phase_q == PH_PAYLOAD);
    wr_o.addr    = count_q;
    wr_o.data    = byte_i;
    frame_o.good = byte_valid_i && !resync_i && (phase_q == PH_CRC) &&
                   (crc_cnt_q != 2'd0) && ({byte_i, crc_low_q} == crc_q);
    frame_o.id   = id_q;
    frame_o.len  = len_q;
  end

  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hdr_pos_q <= 1'b0;
      id_q      <= 8'd0;
      len_q     <= 8'd0;
      count_q   <= 8'd0;
      crc_q     <= CrcSeed;
      crc_low_q <= 8'd0;
      crc_cnt_q <= 2'd0;
    end else begin
      phase_q   <= phase_d;
      hdr_pos_q <= hdr_pos_d;
      id_q      <= id_d;
      len_q     <= len_d;
      count_q   <= count_d;
      crc_q     <= crc_d;
      crc_low_q <= crc_low_d;
      crc_cnt_q <= crc_cnt_d;
    end
  end

  // payload phase never sees a zero length, and the count stays below it
  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> (len_q != 8'd0) && (count_q < len_q))
    else $error("payload count out of range");

  a_wr_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |=> (count_q == $past(count_inc)))
    else $error("payload write without count advance");

  a_good_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.good |=> phase_q == PH_IDLE)
    else $error("good frame did not return to idle");

endmodule

`default_nettype wire

// File: rtl/core/crc_checked_frame_receiver_core.sv
// Top level of the CRC-checked frame receiver: channels, config register, result stage.
//
// Usage:
//   rx_i  : input beats {op, data_byte, read_index}. op RECV feeds one link byte,
//           READ asks for a stored payload byte, RESYNC drops back to idle.
//   res_o : result beats {kind, frame_id, frame_length, read_data}. A frame with a
//           matching CRC-16/CCITT-FALSE gives one kind 0 beat; every READ gives one
//           kind 1 beat (read_data 0 for an index not below the bytes received).
//   cfg_i : start byte register, always ready; write it while the block is idle.
// Throughput is one rx beat per cycle while res_o is not stalled: the byte-wide
// CRC update, the phase update and one payload RAM write all complete in the cycle
// of acceptance. A result shows on res_o the cycle after its rx beat is accepted,
// the read byte coming from the RAM's registered read port.
// A single output register holds a pending result; while it is full and res_o
// is stalled, rx_i ready is low. Reset clears the parser to idle, the CRC to
// its seed and the start byte to 0xAA; the payload RAM is not cleared, reads
// are gated by the received byte count instead.
`default_nettype none

module crc_checked_frame_receiver_core import crcfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  crcfr_chan_if.sink   rx_i,
  crcfr_chan_if.source res_o,
  crcfr_chan_if.sink   cfg_i
);

  crcfr_rx_t    rx;
  logic         rx_acc;
  logic         byte_en;
  logic         resync;
  logic         rd_en;
  logic [7:0]   start_byte_q;
  crcfr_wr_t    wr;
  crcfr_frame_t frame;
  logic [7:0]   count;
  logic [7:0]   rd_data;

  logic         out_valid_q, out_valid_d;
  logic         out_kind_q;
  logic [7:0]   out_id_q;
  logic [7:0]   out_len_q;
  logic         out_hit_q;

  assign rx      = rx_i.data;
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign rx_acc  = rx_i.valid && rx_i.ready;
  assign byte_en = rx_acc && (rx.op == OP_RECV);
  assign resync  = rx_acc && (rx.op == OP_RESYNC);
  assign rd_en   = rx_acc && (rx.op == OP_READ);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
    end else if (cfg_i.valid) begin
      start_byte_q <= cfg_i.data;
    end
  end

  crcfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_en),
    .resync_i     (resync),
    .byte_i       (rx.data_byte),
    .start_byte_i (start_byte_q),
    .wr_o         (wr),
    .frame_o      (frame),
    .count_o      (count)
  );

  crcfr_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rx.read_index),
    .rd_data_o (rd_data)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (rx_acc) begin
      out_valid_d = frame.good || rd_en;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload; range check uses the count before this beat
  always_ff @(posedge clk_i) begin
    if (rx_acc) begin
      out_kind_q <= rd_en ? KindRead : KindFrame;
      out_id_q   <= rd_en ? 8'd0 : frame.id;
      out_len_q  <= rd_en ? 8'd0 : frame.len;
      out_hit_q  <= rd_en && (rx.read_index < count);
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.data.kind         = out_kind_q;
  assign res_o.data.frame_id     = out_id_q;
  assign res_o.data.frame_length = out_len_q;
  assign res_o.data.read_data    = out_hit_q ? rd_data : 8'd0;

  a_read_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> out_valid_q && (out_kind_q == KindRead))
    else $error("read beat lost");

  a_good_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.good |=> out_valid_q && (out_kind_q == KindFrame))
    else $error("good frame beat lost");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |-> !rx_acc)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
